@@ src/wsp_pkg.sv @@
// ----------------------------------------------------------------------------
// wsp_pkg: shared types and constants
// Widths, register indexes and lane control struct for the weighted stdev block.
// ----------------------------------------------------------------------------
package wsp_pkg;

  localparam int FEATURES = 3;

  localparam logic [1:0] REG_NU  = 2'd0;
  localparam logic [1:0] REG_D0  = 2'd1;
  localparam logic [1:0] REG_D1  = 2'd2;
  localparam logic [1:0] REG_D2  = 2'd3;

  typedef enum logic [2:0] {
    ST_ACC,
    ST_NUM,
    ST_DIV,
    ST_SQRT,
    ST_OUT
  } state_t;

  // Control from the sequencer to the finishing lanes.
  typedef struct packed {
    logic load;    // latch numerator inputs
    logic num;     // form numerator
    logic div;     // one divide step
    logic sqrt;    // one root step
    logic start;   // first step of an iterative phase
  } lane_ctl_t;

endpackage

@@ src/wsp_lane.sv @@
// ----------------------------------------------------------------------------
// wsp_lane: one feature lane
// Accumulates weight*(obs-est)^2, then divides and takes the floor root.
// ----------------------------------------------------------------------------
module wsp_lane (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 acc_en,
  input  logic                 clr,
  input  logic signed [15:0]   obs,
  input  logic signed [15:0]   est,
  input  logic [15:0]          weight,
  input  logic [15:0]          dev,
  input  logic [23:0]          nu,
  input  logic [32:0]          den,
  input  wsp_pkg::lane_ctl_t   ctl,
  output logic [15:0]          stdev
);

  // Stage 1: difference squared, registered.
  logic [16:0] mag;
  logic [33:0] sq_r;
  logic [15:0] w_r;
  logic        v_r;
  logic signed [16:0] diff;
  assign diff = 17'(obs) - 17'(est);
  assign mag  = diff[16] ? 17'(-diff) : diff;

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= 1'b0;
    else v_r <= acc_en;
    sq_r <= 34'(mag) * 34'(mag);
    w_r  <= weight;
  end

  // Stage 2: weight product, registered.
  logic [49:0] term_r;
  logic        tv_r;
  always_ff @(posedge clk) begin
    if (!rst_n) tv_r <= 1'b0;
    else tv_r <= v_r;
    term_r <= 50'(sq_r) * 50'(w_r);
  end

  logic [63:0] sum_r;
  logic [64:0] sum_add;
  assign sum_add = 65'(sum_r) + 65'(term_r);
  always_ff @(posedge clk) begin
    if (!rst_n || clr) sum_r <= '0;
    else if (tv_r) sum_r <= sum_add[64] ? '1 : sum_add[63:0];
  end

  // Numerator: d*d then *nu, then saturating add.
  logic [31:0] dd_r;
  logic [63:0] num_r;
  logic [64:0] num_add;
  assign num_add = 65'(56'(dd_r) * 56'(nu)) + 65'(sum_r);
  always_ff @(posedge clk) begin
    if (ctl.load) dd_r <= 32'(dev) * 32'(dev);
    if (ctl.num)  num_r <= num_add[64] ? '1 : num_add[63:0];
  end

  // Restoring divide, one quotient bit a cycle.
  logic [63:0] q_r;
  logic [32:0] rem_r;
  logic [33:0] rtry;
  logic [33:0] rdiff;
  assign rtry  = {rem_r, q_r[63]};
  assign rdiff = rtry - 34'(den);
  always_ff @(posedge clk) begin
    if (ctl.div) begin
      if (ctl.start) begin
        q_r   <= num_r;
        rem_r <= '0;
      end else begin
        if (!rdiff[33]) begin
          rem_r <= rdiff[32:0];
          q_r   <= {q_r[62:0], 1'b1};
        end else begin
          rem_r <= rtry[32:0];
          q_r   <= {q_r[62:0], 1'b0};
        end
      end
    end
  end

  // Digit-by-digit root, two radicand bits a cycle.
  logic [63:0] rad_r;
  logic [33:0] srem_r;
  logic [31:0] root_r;
  logic [33:0] stry;
  logic [33:0] ssub;
  assign stry = {srem_r[31:0], rad_r[63:62]};
  assign ssub = {root_r, 2'b01};
  always_ff @(posedge clk) begin
    if (ctl.sqrt) begin
      if (ctl.start) begin
        rad_r  <= q_r;
        srem_r <= '0;
        root_r <= '0;
      end else begin
        rad_r <= {rad_r[61:0], 2'b00};
        if (stry >= ssub) begin
          srem_r <= stry - ssub;
          root_r <= {root_r[30:0], 1'b1};
        end else begin
          srem_r <= stry;
          root_r <= {root_r[30:0], 1'b0};
        end
      end
    end
  end

  assign stdev = (root_r[31:16] != '0) ? 16'hFFFF : root_r[15:0];

endmodule

@@ src/weighted_stdev_with_prior_top.sv @@
// ----------------------------------------------------------------------------
// weighted_stdev_with_prior_top: weighted stdev with prior, three lanes
// Streams observations per node, emits per-feature floor-root stdev on last.
// ----------------------------------------------------------------------------
// channel | direction | handshake           | payload
// in      | in        | in_valid/in_stall   | weight, obs_*, est_*, last_obs
// out     | out       | out_valid/out_stall | stdev_*, zero_denominator
// cfg     | in        | APB psel/penable    | nu_prior, prior_dev_*
//
// Non-last requests are accepted back to back, one per cycle, while no finish
// sequence runs. A last request runs a finish sequence: it drains the MAC pipe,
// forms the numerator, then runs 65 divide steps and 33 root steps.
// Reset is synchronous active low; accumulators clear at reset and per node.
// Result holds in an output register while out_stall is high; a new node's
// requests are accepted meanwhile, the next last waits for the register.
module weighted_stdev_with_prior_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        in_weight,
  input  logic signed [15:0] in_obs_0,
  input  logic signed [15:0] in_obs_1,
  input  logic signed [15:0] in_obs_2,
  input  logic signed [15:0] in_est_0,
  input  logic signed [15:0] in_est_1,
  input  logic signed [15:0] in_est_2,
  input  logic               in_last_obs,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_stdev_0,
  output logic [15:0]        out_stdev_1,
  output logic [15:0]        out_stdev_2,
  output logic               out_zero_denominator,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // Configuration registers.
  logic [23:0] nu_r;
  logic [15:0] dev_r [3];
  logic        wr;
  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nu_r <= 24'd32768;
      dev_r[0] <= '0;
      dev_r[1] <= '0;
      dev_r[2] <= '0;
    end else if (wr && paddr[1:0] == 2'b00) begin
      case (paddr[3:2])
        wsp_pkg::REG_NU: nu_r <= pwdata[23:0];
        wsp_pkg::REG_D0: dev_r[0] <= pwdata[15:0];
        wsp_pkg::REG_D1: dev_r[1] <= pwdata[15:0];
        wsp_pkg::REG_D2: dev_r[2] <= pwdata[15:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    case (paddr[3:2])
      wsp_pkg::REG_NU: prdata = {8'd0, nu_r};
      wsp_pkg::REG_D0: prdata = {16'd0, dev_r[0]};
      wsp_pkg::REG_D1: prdata = {16'd0, dev_r[1]};
      wsp_pkg::REG_D2: prdata = {16'd0, dev_r[2]};
      default:         prdata = '0;
    endcase
  end

  // Sequencer.
  wsp_pkg::state_t state_r, state_nxt;
  logic [6:0] cnt_r, cnt_nxt;
  wsp_pkg::lane_ctl_t ctl;
  logic acc_en, clr, out_load;
  logic out_free;
  logic [31:0] wt_r;
  logic [32:0] wt_add;
  logic [1:0]  wv_r;
  logic [15:0] w_d1_r, w_d2_r;
  logic [32:0] den;
  logic [15:0] sd [3];

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state_r != wsp_pkg::ST_ACC) || (in_last_obs && out_valid);
  assign acc_en   = in_valid && !in_stall;
  assign den      = 33'(nu_r) + 33'(wt_r);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ctl       = '0;
    clr       = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      wsp_pkg::ST_ACC: begin
        if (acc_en && in_last_obs) begin
          state_nxt = wsp_pkg::ST_NUM;
          cnt_nxt   = 7'd0;
        end
      end
      wsp_pkg::ST_NUM: begin
        // Wait for the two MAC stages to land, then form numerators.
        cnt_nxt  = cnt_r + 7'd1;
        ctl.load = (cnt_r == 7'd0);
        if (cnt_r == 7'd2) begin
          ctl.num   = 1'b1;
          state_nxt = wsp_pkg::ST_DIV;
          cnt_nxt   = 7'd0;
        end
      end
      wsp_pkg::ST_DIV: begin
        ctl.div   = 1'b1;
        ctl.start = (cnt_r == 7'd0);
        cnt_nxt   = cnt_r + 7'd1;
        if (cnt_r == 7'd64) begin
          state_nxt = wsp_pkg::ST_SQRT;
          cnt_nxt   = 7'd0;
        end
      end
      wsp_pkg::ST_SQRT: begin
        ctl.sqrt  = 1'b1;
        ctl.start = (cnt_r == 7'd0);
        cnt_nxt   = cnt_r + 7'd1;
        if (cnt_r == 7'd32) state_nxt = wsp_pkg::ST_OUT;
      end
      wsp_pkg::ST_OUT: begin
        if (out_free) begin
          out_load  = 1'b1;
          clr       = 1'b1;
          state_nxt = wsp_pkg::ST_ACC;
        end
      end
      default: state_nxt = wsp_pkg::ST_ACC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wsp_pkg::ST_ACC;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Weight sum, delayed to line up with the lane MAC pipe.
  assign wt_add = 33'(wt_r) + 33'(w_d2_r);
  always_ff @(posedge clk) begin
    if (!rst_n) wv_r <= '0;
    else wv_r <= {wv_r[0], acc_en};
    w_d1_r <= in_weight;
    w_d2_r <= w_d1_r;
    if (!rst_n || clr) wt_r <= '0;
    else if (wv_r[1]) wt_r <= wt_add[32] ? '1 : wt_add[31:0];
  end

  wsp_lane u_lane0 (.clk, .rst_n, .acc_en, .clr, .obs(in_obs_0), .est(in_est_0),
    .weight(in_weight), .dev(dev_r[0]), .nu(nu_r), .den, .ctl, .stdev(sd[0]));
  wsp_lane u_lane1 (.clk, .rst_n, .acc_en, .clr, .obs(in_obs_1), .est(in_est_1),
    .weight(in_weight), .dev(dev_r[1]), .nu(nu_r), .den, .ctl, .stdev(sd[1]));
  wsp_lane u_lane2 (.clk, .rst_n, .acc_en, .clr, .obs(in_obs_2), .est(in_est_2),
    .weight(in_weight), .dev(dev_r[2]), .nu(nu_r), .den, .ctl, .stdev(sd[2]));

  // Merge: zero denominator forces all stdevs to zero; features past
  // FEATURES always read zero.
  logic zd;
  assign zd = (den == '0);
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (out_load) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
    if (out_load) begin
      out_stdev_0 <= zd ? 16'd0 : sd[0];
      out_stdev_1 <= (zd || wsp_pkg::FEATURES < 2) ? 16'd0 : sd[1];
      out_stdev_2 <= (zd || wsp_pkg::FEATURES < 3) ? 16'd0 : sd[2];
      out_zero_denominator <= zd;
    end
  end

  ap_no_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != wsp_pkg::ST_ACC) |-> in_stall) else $error("accepted while busy");
  ap_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> out_free) else $error("result overwritten");
  ap_clr_wt: assert property (@(posedge clk) disable iff (!rst_n)
    clr |=> (wt_r == '0)) else $error("weight sum not cleared");

endmodule
